@@ src/ddo_pkg.sv @@
// Shared constants and the sine table generator for the odometry block.
package ddo_pkg;

    localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
    localparam logic [63:0] OneQ30    = 64'd1073741824;
    localparam logic [29:0] TurnK     = 30'd683565276;

    localparam logic [15:0] RadiusReset  = 16'd3277;
    localparam logic [15:0] InvTrackReset = 16'd18618;

    localparam logic [2:0] AddrRadius   = 3'd0;
    localparam logic [2:0] AddrInvTrack = 3'd4;

    function automatic logic [16:0] quarter_sine(input int unsigned k, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (64'(k) * HalfPiQ30) >> (bits - 2);
        x2 = (x * x) >> 30;
        t  = OneQ30 - x2 / 64'd110;
        t  = OneQ30 - ((x2 * t) >> 30) / 64'd72;
        t  = OneQ30 - ((x2 * t) >> 30) / 64'd42;
        t  = OneQ30 - ((x2 * t) >> 30) / 64'd20;
        t  = OneQ30 - ((x2 * t) >> 30) / 64'd6;
        return 17'((((x * t) >> 30) + 64'd8192) >> 14);
    endfunction

endpackage

@@ src/ddo_sine.sv @@
// Sine lookup over a full turn, built from a quarter-wave constant table.
module ddo_sine
    import ddo_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  logic [TABLE_BITS-1:0] i_idx,
    output logic signed [17:0]    o_sin
);
    localparam int Q = 1 << (TABLE_BITS - 2);

    logic [16:0]           w_tab [Q+1];
    logic [1:0]            w_quad;
    logic [TABLE_BITS-3:0] w_rem;
    logic [TABLE_BITS-2:0] w_k;
    logic [16:0]           w_mag;

    for (genvar g = 0; g <= Q; g++) begin : g_tab
        assign w_tab[g] = quarter_sine(g, TABLE_BITS);
    end

    always_comb begin
        w_quad = i_idx[TABLE_BITS-1:TABLE_BITS-2];
        w_rem  = i_idx[TABLE_BITS-3:0];
        w_k    = w_quad[0] ? ((TABLE_BITS-1)'(Q) - {1'b0, w_rem}) : {1'b0, w_rem};
        w_mag  = w_tab[w_k];
        o_sin  = w_quad[1] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    end
endmodule

@@ src/ddo_mul.sv @@
// Shared signed multiplier with a registered product.
module ddo_mul (
    input  logic               i_clk,
    input  logic signed [33:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [65:0] o_prod
);
    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 66'(i_a) * 66'(i_b);
    end

    assign o_prod = r_prod;
endmodule

@@ src/differential_drive_odometry.sv @@
// Top level of the differential-drive odometry block.
// Input stream s_*: one item per odometry tick, tdata = {right_angle, left_angle}.
// Output stream m_*: one item per input item with the pose after that tick,
// tdata = {heading, pos_y, pos_x}, tuser = updated.
// APB port: register 0 (address 0) wheel radius, register 1 (address 4)
// inverse track; both read back.
// An accepted item passes S_CHECK and S_FIN when either wheel delta is zero,
// and S_CHECK, S_VL to S_MS and S_FIN when the pose advances; s_tready
// rises as the result enters the output register. A sequencer steps
// one 34x32 multiplier through the two wheel distances, the turn product, the
// two halves of the angle scaling and the cosine and sine terms. s_tready is
// high only while the sequencer idles.
// The result sits in an output register; if the receiver stalls, the
// sequencer holds in its last step until the register frees.
// Reset clears pose, last angles and handshake state and restores register
// defaults; no clearing pass is needed.
module differential_drive_odometry
    import ddo_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // left_angle, right_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // pos_x, pos_y, heading
    output logic        m_tuser,  // updated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int TB = TRIG_TABLE_BITS;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CHECK = 13'b0000000000010,
        S_VL    = 13'b0000000000100,
        S_VR    = 13'b0000000001000,
        S_SUM   = 13'b0000000010000,
        S_P     = 13'b0000000100000,
        S_ABS   = 13'b0000001000000,
        S_MA    = 13'b0000010000000,
        S_MB    = 13'b0000100000000,
        S_ANG   = 13'b0001000000000,
        S_MC    = 13'b0010000000000,
        S_MS    = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } t_state;

    t_state r_state;

    logic [15:0] r_radius, r_invtrack;
    logic [31:0] r_last_l, r_last_r, r_acc_x, r_acc_y;
    logic [15:0] r_acc_hd;
    logic [31:0] r_left, r_right, r_dl, r_dr;
    logic signed [32:0] r_vl, r_vr;
    logic signed [33:0] r_v, r_d;
    logic        r_neg, r_upd;
    logic [49:0] r_mag;
    logic [27:0] r_hi;
    logic [15:0] r_dth;
    logic signed [17:0] r_sin, r_cos;
    logic        r_ovalid;
    logic [79:0] r_odata;
    logic        r_ouser;

    logic signed [33:0] w_a;
    logic signed [31:0] w_b;
    logic signed [65:0] w_prod, w_rnd;
    logic [16:0]        w_hsum;
    logic [TB-1:0]      w_idx, w_cidx;
    logic signed [17:0] w_sin, w_cos;
    logic [63:0]        w_lo;
    logic [27:0]        w_asum;
    logic signed [33:0] w_sum;

    ddo_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_prod(w_prod));

    ddo_sine #(.TABLE_BITS(TB)) u_sin (.i_idx(w_idx), .o_sin(w_sin));
    ddo_sine #(.TABLE_BITS(TB)) u_cos (.i_idx(w_cidx), .o_sin(w_cos));

    always_comb begin
        w_hsum = {1'b0, r_acc_hd} + 17'((1 << (16 - TB)) >> 1);
        w_idx  = w_hsum[15:16-TB];
        w_cidx = w_idx + TB'(1 << (TB - 2));
        w_rnd  = w_prod + 66'sd32768;
        w_lo   = w_prod[63:0] + 64'h0000_0800_0000_0000;
        w_asum = r_hi + w_lo[59:32];
        w_sum  = 34'(r_vr) + 34'(r_vl) + 34'sd1;
    end

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            S_CHECK: begin
                w_a = -34'($signed(r_dl));
                w_b = $signed({16'd0, r_radius});
            end
            S_VL: begin
                w_a = 34'($signed(r_dr));
                w_b = $signed({16'd0, r_radius});
            end
            S_P: begin
                w_a = r_d;
                w_b = $signed({16'd0, r_invtrack});
            end
            S_MA: begin
                w_a = $signed({16'd0, r_mag[49:32]});
                w_b = $signed({2'd0, TurnK});
            end
            S_MB: begin
                w_a = $signed({2'd0, r_mag[31:0]});
                w_b = $signed({2'd0, TurnK});
            end
            S_ANG: begin
                w_a = r_v;
                w_b = 32'(r_cos);
            end
            S_MC: begin
                w_a = r_v;
                w_b = 32'(r_sin);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_radius   <= RadiusReset;
            r_invtrack <= InvTrackReset;
            r_last_l   <= '0;
            r_last_r   <= '0;
            r_acc_x    <= '0;
            r_acc_y    <= '0;
            r_acc_hd   <= '0;
            r_ovalid   <= 1'b0;
            r_upd      <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == AddrRadius) r_radius <= pwdata[15:0];
                if (paddr == AddrInvTrack) r_invtrack <= pwdata[15:0];
            end
            if (r_ovalid && m_tready && r_state != S_FIN) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_left  <= s_tdata[31:0];
                        r_right <= s_tdata[63:32];
                        r_dl    <= s_tdata[31:0] - r_last_l;
                        r_dr    <= s_tdata[63:32] - r_last_r;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_sin <= w_sin;
                    r_cos <= w_cos;
                    if (r_dl == '0 || r_dr == '0) begin
                        r_upd   <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_upd   <= 1'b1;
                        r_state <= S_VL;
                    end
                end
                S_VL: begin
                    r_vl    <= w_rnd[48:16];
                    r_state <= S_VR;
                end
                S_VR: begin
                    r_vr    <= w_rnd[48:16];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_v     <= w_sum >>> 1;
                    r_d     <= 34'(r_vr) - 34'(r_vl);
                    r_state <= S_P;
                end
                S_P: r_state <= S_ABS;
                S_ABS: begin
                    r_neg   <= w_prod[65];
                    r_mag   <= w_prod[65] ? 50'(-w_prod) : w_prod[49:0];
                    r_state <= S_MA;
                end
                S_MA: r_state <= S_MB;
                S_MB: begin
                    r_hi    <= w_prod[27:0];
                    r_state <= S_ANG;
                end
                S_ANG: begin
                    r_dth   <= r_neg ? -w_asum[27:12] : w_asum[27:12];
                    r_state <= S_MC;
                end
                S_MC: begin
                    r_acc_x <= r_acc_x + w_rnd[47:16];
                    r_state <= S_MS;
                end
                S_MS: begin
                    r_acc_y  <= r_acc_y + w_rnd[47:16];
                    r_acc_hd <= r_acc_hd + r_dth;
                    r_last_l <= r_left;
                    r_last_r <= r_right;
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {r_acc_hd, r_acc_y, r_acc_x};
                        r_ouser  <= r_upd;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            AddrRadius:   prdata = {16'd0, r_radius};
            AddrInvTrack: prdata = {16'd0, r_invtrack};
            default:      prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;
    assign m_tuser  = r_ouser;
endmodule

@@ dv/tb_differential_drive_odometry.sv @@
// Testbench for the odometry block: a self-checking pose predictor fed by directed and random ticks.
module tb_differential_drive_odometry;
    import ddo_pkg::*;

    localparam int TableBits = 10;
    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic [31:0] right_angle;
        logic [31:0] left_angle;
    } t_tick;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic        updated;
    } t_pose;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    differential_drive_odometry #(.TRIG_TABLE_BITS(TableBits)) u_dut (.*);

    t_tick       tick_q[$];
    t_pose       pose_q[$];
    int          errors;
    int          idle_cycles;
    int          send_wait;
    int          recv_wait;
    int          hold_off;
    logic [15:0] radius;
    logic [15:0] inv_track;
    logic [31:0] last_l, last_r, acc_x, acc_y;
    logic [15:0] acc_hdg;
    longint      sine_tab[1 << TableBits];

    function automatic longint round_shift(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint quad_sine(longint k);
        logic [63:0] x, x2, t;
        x  = (64'(k) * 64'd1686629713) >> (TableBits - 2);
        x2 = (x * x) >> 30;
        t  = 64'd1073741824 - x2 / 110;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
        return longint'((((x * t) >> 30) + 64'd8192) >> 14);
    endfunction

    function automatic logic [15:0] turn_of(longint p);
        logic [63:0] m, a, b, r;
        m = (p < 0) ? 64'(-p) : 64'(p);
        a = (m >> 32) * 64'd683565276;
        b = (m & 64'hFFFF_FFFF) * 64'd683565276 + (64'd1 << 43);
        r = (a + (b >> 32)) >> 12;
        if (p < 0) r = -r;
        return r[15:0];
    endfunction

    function automatic t_pose advance_pose(t_tick tk);
        t_pose  res;
        longint dl, dr, vl, vr, v, p, s, c;
        int     idx;
        int     q;
        dl = longint'($signed(tk.left_angle - last_l));
        dr = longint'($signed(tk.right_angle - last_r));
        res.updated = 1'b0;
        if (dl != 0 && dr != 0) begin
            vl = round_shift(-dl * longint'(radius), 16);
            vr = round_shift(dr * longint'(radius), 16);
            v  = round_shift(vr + vl, 1);
            p  = (vr - vl) * longint'(inv_track);
            idx = ((int'(acc_hdg) + ((1 << (16 - TableBits)) >> 1)) >> (16 - TableBits));
            q = 1 << (TableBits - 2);
            s = sine_tab[idx % (1 << TableBits)];
            c = sine_tab[(idx + q) % (1 << TableBits)];
            acc_x   = acc_x + 32'(round_shift(v * c, 16));
            acc_y   = acc_y + 32'(round_shift(v * s, 16));
            acc_hdg = acc_hdg + turn_of(p);
            last_l  = tk.left_angle;
            last_r  = tk.right_angle;
            res.updated = 1'b1;
        end
        res.pos_x = acc_x;
        res.pos_y = acc_y;
        res.heading = acc_hdg;
        return res;
    endfunction

    initial begin
        int sz, qt, r;
        sz = 1 << TableBits;
        qt = sz >> 2;
        for (int i = 0; i < sz; i++) begin
            r = i & (qt - 1);
            sine_tab[i] = ((i >> (TableBits - 2)) & 1) ? quad_sine(qt - r) : quad_sine(r);
            if (((i >> (TableBits - 2)) & 2) != 0) sine_tab[i] = -sine_tab[i];
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_wait <= 0;
        end else if (s_tvalid && !s_tready) begin
        end else if (send_wait > 0) begin
            s_tvalid  <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (tick_q.size() > 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= tick_q.pop_front();
            send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) pose_q.push_back(advance_pose(t_tick'(s_tdata)));
    end

    // monitor
    always @(posedge i_clk) begin
        t_pose exp_p;
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    errors++;
                end else begin
                    exp_p = pose_q.pop_front();
                    if (m_tdata[31:0] !== exp_p.pos_x || m_tdata[63:32] !== exp_p.pos_y
                        || m_tdata[79:64] !== exp_p.heading || m_tuser !== exp_p.updated) begin
                        $display("%0t: expected x=%h y=%h h=%h u=%b actual x=%h y=%h h=%h u=%b",
                                 $time, exp_p.pos_x, exp_p.pos_y, exp_p.heading,
                                 exp_p.updated, m_tdata[31:0], m_tdata[63:32],
                                 m_tdata[79:64], m_tuser);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                hold_off <= hold_off - 1;
            end else if (recv_wait > 0) begin
                m_tready  <= 1'b0;
                recv_wait <= recv_wait - 1;
            end else if (m_tvalid && m_tready) begin
                recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom_range(0, 65535)), 16'h0} | 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == AddrRadius) radius = val;
        else inv_track = val;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (tick_q.size() > 0 || s_tvalid || pose_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand32;
        return $urandom();
    endfunction

    task automatic add_tick(input logic [31:0] l, input logic [31:0] r);
        tick_q.push_back('{right_angle: r, left_angle: l});
    endtask

    task automatic random_run(input int n);
        logic [31:0] l, r;
        l = 0;
        r = 0;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: add_tick(rand32(), rand32());
                1: add_tick(l, rand32());
                2: add_tick(rand32(), r);
                3: begin
                    l = l + 32'($signed(16'($urandom())));
                    r = r + 32'($signed(16'($urandom())));
                    add_tick(l, r);
                end
                default: begin
                    l = l - 32'($urandom_range(1, 40000));
                    r = r + 32'($urandom_range(1, 40000)) - 32'($urandom_range(0, 20000));
                    add_tick(l, r);
                end
            endcase
        end
    endtask

    initial begin
        errors = 0;
        hold_off = 0;
        radius = RadiusReset;
        inv_track = InvTrackReset;
        last_l = 0; last_r = 0; acc_x = 0; acc_y = 0; acc_hdg = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = 0; m_tready = 0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_tick(32'h0, 32'h0);
        add_tick(32'h7FFF_FFFF, 32'h0);
        add_tick(32'h0, 32'h8000_0000);
        add_tick(32'h8000_0000, 32'h7FFF_FFFF);
        add_tick(32'hFFFF_FFFF, 32'h8000_0000);
        add_tick(32'hFFFF_0000, 32'h0001_0000);
        add_tick(32'hFFFF_0001, 32'h0001_0000);
        for (int i = 0; i < 8; i++) add_tick(-32'(i * 25000 + 1), 32'(i * 30000 + 1));
        add_tick(32'h1234_5678, 32'h8765_4321);
        drain();

        reg_write(AddrRadius, 16'hFFFF);
        reg_write(AddrInvTrack, 16'hFFFF);
        add_tick(32'h0, 32'h8000_0000);
        add_tick(32'h8000_0000, 32'h0);
        add_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_run(150);
        hold_off = 300;
        drain();

        reg_write(AddrRadius, 16'h0);
        reg_write(AddrInvTrack, 16'h0);
        random_run(100);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            reg_write(AddrRadius, 16'($urandom()));
            reg_write(AddrInvTrack, 16'($urandom()));
            random_run(180);
            drain();
        end

        reg_write(AddrRadius, RadiusReset);
        reg_write(AddrInvTrack, InvTrackReset);
        random_run(100);
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
